FILE: hdl/tlo_pkg.sv
// Shared types, constants and helper functions for the texel lerp and over-composite pipeline.
package tlo_pkg;

  localparam int unsigned TEXEL_W   = 32;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned PROD_W    = 16;

  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] CHAN_MAX     = 8'd255;

  // Stage 1 -> stage 2: interpolated source and widened destination channels.
  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
    logic [CHAN_W-1:0]  dst_r8;
    logic [CHAN_W-1:0]  dst_g8;
    logic [CHAN_W-1:0]  dst_b8;
    logic [PIXEL_W-1:0] dst;
  } lerp_out_t;

  // Stage 2 -> stage 3: destination channels scaled by the inverse alpha.
  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
    logic [PROD_W-1:0]  prod_r;
    logic [PROD_W-1:0]  prod_g;
    logic [PROD_W-1:0]  prod_b;
    logic [PIXEL_W-1:0] dst;
  } scale_out_t;

  // floor(d*255/31) = 8d + floor(7d/31); the fraction steps at these codes.
  function automatic logic [7:0] expand5(input logic [4:0] d);
    logic [2:0] frac;
    frac = 3'd0;
    if (d >= 5'd5)  frac = 3'd1;
    if (d >= 5'd9)  frac = 3'd2;
    if (d >= 5'd14) frac = 3'd3;
    if (d >= 5'd18) frac = 3'd4;
    if (d >= 5'd23) frac = 3'd5;
    if (d >= 5'd27) frac = 3'd6;
    if (d == 5'd31) frac = 3'd7;
    return {d, 3'b000} + {5'd0, frac};
  endfunction

  // floor(d*255/63) = 4d + floor(d/21).
  function automatic logic [7:0] expand6(input logic [5:0] d);
    logic [1:0] frac;
    frac = 2'd0;
    if (d >= 6'd21) frac = 2'd1;
    if (d >= 6'd42) frac = 2'd2;
    if (d == 6'd63) frac = 2'd3;
    return {d, 2'b00} + {6'd0, frac};
  endfunction

  // floor(x/255), exact for x up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

FILE: hdl/texel_lerp_over_rgb565.sv
// Top level of the texel interpolation and premultiplied-alpha over composite into RGB565.
//
// Each item is two premultiplied RGBA8888 texels, an 8-bit weight and the current RGB565
// destination pixel; the block returns one new RGB565 pixel per item. A new item may be
// issued on every clock (busy stays low), and its result appears on composited_pixel with
// done high for one cycle once the item has passed the last stage. The three register
// stages are interpolation with destination widening, the inverse-alpha multiply, and the
// divide by 255 with saturation and packing. The receiver cannot stall the output, so each
// result must be captured in the cycle that done is high.
module texel_lerp_over_rgb565
  import tlo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [TEXEL_W-1:0] texel_first,
  input  logic [TEXEL_W-1:0] texel_second,
  input  logic [CHAN_W-1:0]  blend_weight,
  input  logic [PIXEL_W-1:0] dst_pixel,
  output logic               done,
  output logic [PIXEL_W-1:0] composited_pixel
);

  logic       accept;
  logic       lerp_valid;
  lerp_out_t  lerp_data;
  logic       scale_valid;
  scale_out_t scale_data;

  // the pipeline never stalls, so an item is taken whenever start is high
  assign busy   = 1'b0;
  assign accept = start && !busy;

  tlo_lerp u_lerp (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .texel_first  (texel_first),
    .texel_second (texel_second),
    .blend_weight (blend_weight),
    .dst_pixel    (dst_pixel),
    .out_valid    (lerp_valid),
    .out_data     (lerp_data)
  );

  tlo_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lerp_valid),
    .in_data   (lerp_data),
    .out_valid (scale_valid),
    .out_data  (scale_data)
  );

  tlo_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scale_valid),
    .in_data   (scale_data),
    .out_valid (done),
    .out_pixel (composited_pixel)
  );

  // every accepted item comes out as a done strobe
  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted item was not delivered three cycles later");

  // no result without a matching item taken before it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result strobe without a matching item");

endmodule

FILE: hdl/tlo_lerp.sv
// Stage 1: per-channel texel interpolation and destination channel widening.
module tlo_lerp
  import tlo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [TEXEL_W-1:0] texel_first,
  input  logic [TEXEL_W-1:0] texel_second,
  input  logic [CHAN_W-1:0]  blend_weight,
  input  logic [PIXEL_W-1:0] dst_pixel,
  output logic               out_valid,
  output lerp_out_t          out_data
);

  logic [8:0]         weight_inv;
  logic [TEXEL_W-1:0] texel_mix;
  lerp_out_t          data_next;

  assign weight_inv = 9'd256 - {1'b0, blend_weight};

  always_comb begin
    logic [16:0] acc;
    for (int c = 0; c < CHANNELS; c++) begin
      acc = ({9'd0, texel_first[c*CHAN_W +: CHAN_W]} * {8'd0, weight_inv})
          + ({9'd0, texel_second[c*CHAN_W +: CHAN_W]} * {9'd0, blend_weight});
      texel_mix[c*CHAN_W +: CHAN_W] = acc[15:8];
    end
  end

  always_comb begin
    data_next.texel  = texel_mix;
    data_next.dst_r8 = expand5(dst_pixel[15:11]);
    data_next.dst_g8 = expand6(dst_pixel[10:5]);
    data_next.dst_b8 = expand5(dst_pixel[4:0]);
    data_next.dst    = dst_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

FILE: hdl/tlo_scale.sv
// Stage 2: scale the widened destination channels by the inverse source alpha.
module tlo_scale
  import tlo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  lerp_out_t  in_data,
  output logic       out_valid,
  output scale_out_t out_data
);

  logic [CHAN_W-1:0] alpha_inv;
  scale_out_t        data_next;

  assign alpha_inv = CHAN_MAX - in_data.texel[31:24];

  always_comb begin
    data_next.texel  = in_data.texel;
    data_next.prod_r = {8'd0, in_data.dst_r8} * {8'd0, alpha_inv};
    data_next.prod_g = {8'd0, in_data.dst_g8} * {8'd0, alpha_inv};
    data_next.prod_b = {8'd0, in_data.dst_b8} * {8'd0, alpha_inv};
    data_next.dst    = in_data.dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

FILE: hdl/tlo_blend.sv
// Stage 3: divide by 255, add with saturation, pack to RGB565 and pick the special cases.
module tlo_blend
  import tlo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  scale_out_t         in_data,
  output logic               out_valid,
  output logic [PIXEL_W-1:0] out_pixel
);

  logic [CHAN_W-1:0]  alpha;
  logic [CHAN_W-1:0]  sum_r;
  logic [CHAN_W-1:0]  sum_g;
  logic [CHAN_W-1:0]  sum_b;
  logic [PIXEL_W-1:0] pixel_next;

  function automatic logic [7:0] add_sat(input logic [7:0] s, input logic [15:0] prod);
    logic [8:0] v;
    v = {1'b0, s} + {1'b0, div255(prod)};
    return v[8] ? CHAN_MAX : v[7:0];
  endfunction

  assign alpha = in_data.texel[31:24];
  assign sum_r = add_sat(in_data.texel[7:0],   in_data.prod_r);
  assign sum_g = add_sat(in_data.texel[15:8],  in_data.prod_g);
  assign sum_b = add_sat(in_data.texel[23:16], in_data.prod_b);

  always_comb begin
    if (alpha == ALPHA_CLEAR) begin
      pixel_next = in_data.dst;
    end else if (alpha == ALPHA_OPAQUE) begin
      pixel_next = {in_data.texel[7:3], in_data.texel[15:10], in_data.texel[23:19]};
    end else begin
      pixel_next = {sum_r[7:3], sum_g[7:2], sum_b[7:3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel <= pixel_next;
  end

  // transparent source leaves the destination as it was
  a_clear_passes_dst: assert property (@(posedge clk) disable iff (rst)
    (in_valid && alpha == ALPHA_CLEAR) |=> (out_valid && out_pixel == $past(in_data.dst)))
    else $error("transparent item did not return the destination pixel");

  // opaque source ignores the destination
  a_opaque_packs_src: assert property (@(posedge clk) disable iff (rst)
    (in_valid && alpha == ALPHA_OPAQUE) |=>
      (out_pixel == {$past(in_data.texel[7:3]), $past(in_data.texel[15:10]),
                     $past(in_data.texel[23:19])}))
    else $error("opaque item did not pack the source pixel");

endmodule

FILE: verif/tb_texel_lerp_over_rgb565.sv
// Testbench for texel_lerp_over_rgb565: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_texel_lerp_over_rgb565
  import tlo_pkg::*;
();

  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned GAP_PERCENT   = 23;
  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned GAPLESS_ITEMS = 300;
  localparam int unsigned REPORT_LIMIT  = 10;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [TEXEL_W-1:0] texel_first;
  logic [TEXEL_W-1:0] texel_second;
  logic [CHAN_W-1:0]  blend_weight;
  logic [PIXEL_W-1:0] dst_pixel;
  logic               done;
  logic [PIXEL_W-1:0] composited_pixel;

  logic [PIXEL_W-1:0] pending_pixels[$];
  logic [PIXEL_W-1:0] want_pixel;
  int unsigned        mismatches;
  int unsigned        stall_cycles;
  bit                 gapless;

  texel_lerp_over_rgb565 u_top (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .texel_first      (texel_first),
    .texel_second     (texel_second),
    .blend_weight     (blend_weight),
    .dst_pixel        (dst_pixel),
    .done             (done),
    .composited_pixel (composited_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Interpolate each byte lane, then composite the premultiplied source over dst.
  function automatic logic [PIXEL_W-1:0] composite_over(input logic [TEXEL_W-1:0] t0,
                                                         input logic [TEXEL_W-1:0] t1,
                                                         input logic [CHAN_W-1:0] w,
                                                         input logic [PIXEL_W-1:0] dst);
    logic [CHAN_W-1:0] src[CHANNELS];
    int unsigned       dst8[3];
    int unsigned       sum[3];
    int unsigned       a, b, wt, inv;
    wt = 32'(w);
    for (int c = 0; c < CHANNELS; c++) begin
      a = 32'(t0[8*c +: 8]);
      b = 32'(t1[8*c +: 8]);
      src[c] = 8'((a * (256 - wt) + b * wt) >> 8);
    end
    if (src[3] == ALPHA_CLEAR) return dst;
    if (src[3] == ALPHA_OPAQUE) return {src[0][7:3], src[1][7:2], src[2][7:3]};
    a = 32'(dst[15:11]);
    dst8[0] = a * 255 / 31;
    a = 32'(dst[10:5]);
    dst8[1] = a * 255 / 63;
    a = 32'(dst[4:0]);
    dst8[2] = a * 255 / 31;
    inv = 32'(CHAN_MAX - src[3]);
    for (int c = 0; c < 3; c++) begin
      sum[c] = 32'(src[c]) + dst8[c] * inv / 255;
      if (sum[c] > 32'(CHAN_MAX)) sum[c] = 32'(CHAN_MAX);
    end
    return {sum[0][7:3], sum[1][7:2], sum[2][7:3]};
  endfunction

  // Premultiplied texel: every colour byte at or below the given alpha.
  function automatic logic [TEXEL_W-1:0] premul_texel(input logic [7:0] alpha);
    return {alpha, 8'($urandom_range(alpha)), 8'($urandom_range(alpha)),
            8'($urandom_range(alpha))};
  endfunction

  task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] want,
                                 input logic [PIXEL_W-1:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected %04h actual %04h", $realtime, what, want, got);
  endtask

  // Predict on acceptance, then check the oldest prediction on each done.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (start && !busy)
        pending_pixels.push_back(composite_over(texel_first, texel_second, blend_weight,
                                                dst_pixel));
      if (done) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("result with no item pending", '0, composited_pixel);
        end else begin
          want_pixel = pending_pixels.pop_front();
          if (composited_pixel !== want_pixel)
            report_mismatch("composited_pixel mismatch", want_pixel, composited_pixel);
        end
      end
      if ((start && !busy) || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Hold the item on the ports until the block takes it; idle at random first unless gapless.
  task automatic send_item(input logic [TEXEL_W-1:0] t0, input logic [TEXEL_W-1:0] t1,
                           input logic [CHAN_W-1:0] w, input logic [PIXEL_W-1:0] d);
    if (!gapless && $urandom_range(99) < GAP_PERCENT) begin
      start        <= 1'b0;
      texel_first  <= $urandom();
      texel_second <= $urandom();
      blend_weight <= 8'($urandom());
      dst_pixel    <= 16'($urandom());
      do @(posedge clk); while ($urandom_range(99) < GAP_PERCENT);
    end
    texel_first  <= t0;
    texel_second <= t1;
    blend_weight <= w;
    dst_pixel    <= d;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic test_directed;
    logic [TEXEL_W-1:0] t;
    t = $urandom();
    send_item('0, '0, '0, '0);
    send_item('1, '1, '1, '1);
    send_item('1, '0, '1, '1);
    send_item('0, '1, '1, '0);
    // zero weight passes the first texel through
    send_item(t, $urandom(), '0, 16'($urandom()));
    send_item(premul_texel(8'($urandom_range(1, 254))), $urandom(), '0, 16'($urandom()));
    // transparent source leaves dst alone
    send_item({8'h00, 24'($urandom())}, {8'h00, 24'($urandom())}, 8'($urandom()),
              16'hffff);
    send_item({8'h00, 24'h000000}, {8'h00, 24'hffffff}, 8'd255, 16'h1234);
    // opaque source ignores dst
    send_item({ALPHA_OPAQUE, 24'($urandom())}, {ALPHA_OPAQUE, 24'($urandom())},
              8'($urandom()), 16'($urandom()));
    send_item({ALPHA_OPAQUE, 24'hffffff}, {ALPHA_OPAQUE, 24'h000000}, 8'd128, 16'hffff);
    // alpha one step from each end, and a mid-way mix of clear and opaque
    send_item({8'd1, 24'h010101}, {8'd1, 24'h000100}, 8'($urandom()), 16'hffff);
    send_item({8'd254, 24'hfefefe}, {8'd254, 24'h000000}, 8'd0, 16'hffff);
    send_item({8'd0, 24'h000000}, {ALPHA_OPAQUE, 24'hffffff}, 8'd128, 16'h8410);
    send_item({8'd0, 24'h000000}, {ALPHA_OPAQUE, 24'hffffff}, 8'd255, 16'hffff);
    // colour above alpha saturates per channel; then mixed texels over assorted dst pixels
    send_item({8'd16, 24'hffffff}, {8'd16, 24'hffffff}, 8'($urandom()), 16'hffff);
    send_item({8'd128, 24'hff00ff}, {8'd128, 24'h00ff00}, 8'd128, 16'hffff);
    send_item({8'd200, 24'h0000ff}, {8'd1, 24'hff0000}, 8'd255, 16'h0000);
    send_item(premul_texel(8'd128), premul_texel(8'd128), 8'd64, 16'hf800);
    send_item(premul_texel(8'd128), premul_texel(8'd128), 8'd192, 16'h07e0);
    send_item(premul_texel(8'd128), premul_texel(8'd128), 8'd1, 16'h001f);
  endtask

  task automatic send_random_item;
    logic [TEXEL_W-1:0] t0, t1;
    logic [CHAN_W-1:0]  w;
    int unsigned        pick;
    pick = $urandom_range(99);
    w = 8'($urandom());
    if ($urandom_range(9) == 0) w = $urandom_range(1) ? '0 : '1;
    if (pick < 20) begin
      t0 = $urandom();
      t1 = $urandom();
    end else if (pick < 30) begin
      t0 = {ALPHA_CLEAR, 24'($urandom())};
      t1 = {ALPHA_CLEAR, 24'($urandom())};
    end else if (pick < 40) begin
      t0 = {ALPHA_OPAQUE, 24'($urandom())};
      t1 = {ALPHA_OPAQUE, 24'($urandom())};
    end else begin
      t0 = premul_texel(8'($urandom()));
      t1 = premul_texel(8'($urandom()));
    end
    send_item(t0, t1, w, 16'($urandom()));
  endtask

  task automatic test_random_texels;
    for (int i = 0; i < RANDOM_ITEMS; i++) send_random_item();
  endtask

  task automatic test_back_to_back;
    gapless = 1'b1;
    for (int i = 0; i < GAPLESS_ITEMS; i++) send_random_item();
    gapless = 1'b0;
  endtask

  initial begin
    mismatches   = 0;
    gapless      = 1'b0;
    rst          <= 1'b1;
    start        <= 1'b0;
    texel_first  <= '0;
    texel_second <= '0;
    blend_weight <= '0;
    dst_pixel    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_texels();
    test_back_to_back();
    test_random_texels();

    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
